// ----- rtl/cmb_pkg.sv -----
// ============================================================================
// cmb_pkg
// Shared types, constants and helpers for the clock-synced mute bank.
// ============================================================================
package cmb_pkg;

    localparam int MAX_CHANNELS      = 8;
    localparam int DEF_COUNT_WIDTH   = 24;
    localparam int RATIO_W           = 7;
    localparam int MAG_W             = 6;
    localparam int GAIN_W            = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 56;
    localparam int PERIOD_W          = 24;
    localparam int IGNORE_W          = 16;
    localparam int STEP_W            = 16;

    localparam logic [GAIN_W-1:0]    GAIN_FULL    = 16'hFFFF;
    localparam logic [RATIO_W-1:0]   RATIO_LIMIT  = 7'd32;

    // register reset values
    localparam logic [CFG_DATA_W-1:0]   RATIOS_RST = '0;
    localparam logic [MAX_CHANNELS-1:0] AUTO_RST   = 8'h00;
    localparam logic [MAX_CHANNELS-1:0] SOFT_RST   = 8'hFF;
    localparam logic [PERIOD_W-1:0]     PERIOD_RST = 24'd24000;
    localparam logic [IGNORE_W-1:0]     IGNORE_RST = 16'd48;
    localparam logic [STEP_W-1:0]       STEP_RST   = 16'd34;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATIOS = 3'd0,
        REG_AUTO   = 3'd1,
        REG_SOFT   = 3'd2,
        REG_PERIOD = 3'd3,
        REG_IGNORE = 3'd4,
        REG_RAMP   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                    clock_edge;
        logic                    reset_edge;
        logic                    clock_present;
        logic [MAX_CHANNELS-1:0] press_mask;
    } in_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]       gain_ch0;
        logic [GAIN_W-1:0]       gain_ch1;
        logic [GAIN_W-1:0]       gain_ch2;
        logic [GAIN_W-1:0]       gain_ch3;
        logic [GAIN_W-1:0]       gain_ch4;
        logic [GAIN_W-1:0]       gain_ch5;
        logic [GAIN_W-1:0]       gain_ch6;
        logic [GAIN_W-1:0]       gain_ch7;
        logic [MAX_CHANNELS-1:0] muted_mask;
        logic [MAX_CHANNELS-1:0] pending_mask;
    } out_item_t;

    // timebase decisions for the transaction being committed
    typedef struct packed {
        logic tick;
        logic restart;
        logic t_zero;
        logic t_sat;
    } tb_flags_t;

    typedef struct packed {
        logic commit;
        logic tick;
        logic rst;
        logic restart;
        logic t_zero;
        logic t_sat;
        logic press;
        logic auto_en;
        logic soft_en;
        logic eng_start;
        logic eng_step;
        logic eng_last;
    } lane_ctl_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              muted;
        logic              pending;
        logic              mod_ok;
    } lane_out_t;

    typedef struct packed {
        logic             neg;
        logic             pos;
        logic [MAG_W-1:0] mag;
    } ratio_t;

    // two's complement ratio, clamped to -32..32
    function automatic ratio_t ratio_decode(input logic [RATIO_W-1:0] raw);
        ratio_t             r;
        logic [RATIO_W-1:0] abs_v;
        abs_v = raw[RATIO_W-1] ? (~raw + 1'b1) : raw;
        r.neg = raw[RATIO_W-1];
        r.pos = !raw[RATIO_W-1] && (raw != '0);
        r.mag = (abs_v > RATIO_LIMIT) ? RATIO_LIMIT[MAG_W-1:0] : abs_v[MAG_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/cmb_timebase.sv -----
// ============================================================================
// cmb_timebase
// Clock period measurement, internal clock, ignore window and tick decision.
// ============================================================================
module cmb_timebase #(
    parameter int COUNT_WIDTH = cmb_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           commit,
    input  cmb_pkg::in_item_t              item,
    input  logic [cmb_pkg::PERIOD_W-1:0]   default_period,
    input  logic [cmb_pkg::IGNORE_W-1:0]   ignore_ticks,
    output cmb_pkg::tb_flags_t             flags,
    output logic [COUNT_WIDTH-1:0]         p_ch,
    output logic [COUNT_WIDTH-1:0]         t_now
);
    import cmb_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic [COUNT_WIDTH-1:0] timer_reg, timer_next;
    logic [COUNT_WIDTH-1:0] tsc_reg, tsc_next;
    logic                   ignore_reg, ignore_next;
    logic                   was_reg;

    logic                   ign;
    logic                   changed;
    logic                   tick;
    logic                   restart;
    logic [COUNT_WIDTH-1:0] tsc_v;

    always_comb
    begin
        ign         = ignore_reg && !(tsc_reg >= COUNT_WIDTH'(ignore_ticks));
        changed     = item.clock_present != was_reg;
        period_next = period_reg;
        timer_next  = timer_reg;
        tsc_v       = tsc_reg;
        ignore_next = ign;
        tick        = 1'b0;
        restart     = 1'b0;
        if (!ign)
        begin
            if (item.clock_present)
            begin
                if (changed)
                begin
                    tsc_v       = '0;
                    ignore_next = 1'b1;
                    restart     = 1'b1;
                end
                timer_next = (timer_reg == CMAX) ? CMAX : timer_reg + 1'b1;
                if (timer_next > period_next)
                begin
                    period_next = timer_next;
                end
                if (item.clock_edge)
                begin
                    period_next = timer_next;
                    timer_next  = '0;
                    tick        = 1'b1;
                    tsc_v       = '0;
                end
            end
            else
            begin
                if (changed)
                begin
                    period_next = COUNT_WIDTH'(default_period);
                end
                if (tsc_v >= period_next)
                begin
                    tick  = 1'b1;
                    tsc_v = '0;
                end
            end
        end
        p_ch = period_next;
        if (item.reset_edge)
        begin
            tsc_v       = '0;
            ignore_next = 1'b1;
        end
        tsc_next = (tsc_v == CMAX) ? CMAX : tsc_v + 1'b1;

        flags.tick    = tick;
        flags.restart = restart;
        flags.t_zero  = tick || restart || item.reset_edge;
        flags.t_sat   = tsc_reg == CMAX;
        t_now         = tsc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= COUNT_WIDTH'(PERIOD_RST);
            timer_reg  <= '0;
            tsc_reg    <= '0;
            ignore_reg <= 1'b1;
            was_reg    <= 1'b1;
        end
        else if (commit)
        begin
            period_reg <= period_next;
            timer_reg  <= timer_next;
            tsc_reg    <= tsc_next;
            ignore_reg <= ignore_next;
            was_reg    <= item.clock_present;
        end
    end

endmodule

// ----- rtl/cmb_lane.sv -----
// ============================================================================
// cmb_lane
// One channel: divider, multiplier phase, pending and mute, gain ramp, and a
// bit-serial remainder unit for the multiplier phase.
// ============================================================================
module cmb_lane #(
    parameter int COUNT_WIDTH = cmb_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmb_pkg::lane_ctl_t            ctl,
    input  logic [cmb_pkg::RATIO_W-1:0]   ratio_raw,
    input  logic [cmb_pkg::STEP_W-1:0]    ramp_step,
    input  logic [COUNT_WIDTH-1:0]        p_ch,
    input  logic [COUNT_WIDTH-1:0]        p_eng,
    input  logic [COUNT_WIDTH-1:0]        t_now,
    output cmb_pkg::lane_out_t            result
);
    import cmb_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + MAG_W;
    localparam int SUMG_W = GAIN_W + MAG_W;

    logic [MAG_W-1:0]       count_reg, count_next;
    logic [COUNT_WIDTH-1:0] accum_reg, accum_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic                   pend_reg, pend_next;
    logic                   mute_reg, mute_next;
    logic [COUNT_WIDTH-1:0] mod_reg, mod_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;

    ratio_t                 rat;
    logic                   zero_r;
    logic                   hit;
    logic                   pend0;
    logic [MAG_W-1:0]       cnt_base;
    logic [MAG_W-1:0]       cnt_inc;
    logic [COUNT_WIDTH-1:0] cur;
    logic [MAG_W-1:0]       step_mul;
    logic [SUMG_W-1:0]      step_amt;
    logic [SUMG_W:0]        up_sum;
    logic [COUNT_WIDTH-1:0] p_eff;
    logic [COUNT_WIDTH:0]   msum;
    logic [COUNT_WIDTH:0]   mdiff;
    logic                   mod_ok;
    logic [COUNT_WIDTH-1:0] pe_eff;
    logic [COUNT_WIDTH:0]   shifted;
    logic [COUNT_WIDTH:0]   reduced;

    always_comb
    begin
        rat    = ratio_decode(ratio_raw);
        zero_r = !rat.neg && !rat.pos;
        hit    = 1'b0;
        pend0  = pend_reg ^ ctl.press;

        // divide: count clock ticks up to the ratio
        cnt_base   = ctl.restart ? '0 : count_reg;
        cnt_inc    = cnt_base + 1'b1;
        count_next = '0;
        if (rat.neg)
        begin
            count_next = cnt_base;
            if (ctl.tick && !ctl.rst)
            begin
                if (cnt_inc >= rat.mag)
                begin
                    count_next = '0;
                    hit        = 1'b1;
                end
                else
                begin
                    count_next = cnt_inc;
                end
            end
            if (ctl.rst)
            begin
                count_next = '0;
            end
        end

        // multiply: a wrap of the phase is a hit
        cur        = ctl.t_zero ? '0 : mod_reg;
        accum_next = '0;
        if (rat.pos)
        begin
            if (cur < accum_reg)
            begin
                hit = 1'b1;
            end
            accum_next = cur;
        end
        if (ctl.rst || (pend0 && zero_r))
        begin
            hit = 1'b1;
        end
        if (hit)
        begin
            accum_next = '0;
        end

        mute_next = mute_reg;
        pend_next = pend0;
        if (pend0 && hit)
        begin
            mute_next = !mute_reg;
            pend_next = 1'b0;
        end
        if (!zero_r && ctl.auto_en && hit)
        begin
            pend_next = 1'b1;
        end

        // gain
        step_mul = rat.pos ? rat.mag : MAG_W'(1);
        step_amt = SUMG_W'(ramp_step) * SUMG_W'(step_mul);
        up_sum   = (SUMG_W + 1)'(gain_reg) + (SUMG_W + 1)'(step_amt);
        if (!ctl.soft_en)
        begin
            gain_next = mute_next ? '0 : GAIN_FULL;
        end
        else if (mute_next)
        begin
            gain_next = (SUMG_W'(gain_reg) > step_amt) ? gain_reg - step_amt[GAIN_W-1:0] : '0;
        end
        else
        begin
            gain_next = (up_sum > (SUMG_W + 1)'(GAIN_FULL)) ? GAIN_FULL : up_sum[GAIN_W-1:0];
        end

        // phase for the following tick: add the ratio, one wrap at most
        p_eff = (p_ch == '0) ? COUNT_WIDTH'(1) : p_ch;
        if (ctl.t_zero)
        begin
            msum = (COUNT_WIDTH + 1)'(rat.mag);
        end
        else if (ctl.t_sat)
        begin
            msum = {1'b0, mod_reg};
        end
        else
        begin
            msum = {1'b0, mod_reg} + (COUNT_WIDTH + 1)'(rat.mag);
        end
        mdiff    = msum - {1'b0, p_eff};
        mod_ok   = 1'b1;
        mod_next = '0;
        if (rat.pos)
        begin
            if (msum < {1'b0, p_eff})
            begin
                mod_next = msum[COUNT_WIDTH-1:0];
            end
            else if (mdiff < {1'b0, p_eff})
            begin
                mod_next = mdiff[COUNT_WIDTH-1:0];
            end
            else
            begin
                mod_ok   = 1'b0;
                mod_next = mod_reg;
            end
        end

        // restoring remainder step, one product bit a cycle
        pe_eff  = (p_eng == '0) ? COUNT_WIDTH'(1) : p_eng;
        shifted = {rem_reg, prod_reg[PROD_W-1]};
        reduced = (shifted >= {1'b0, pe_eff}) ? shifted - {1'b0, pe_eff} : shifted;

        result.gain    = gain_next;
        result.muted   = mute_next;
        result.pending = pend_next;
        result.mod_ok  = mod_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            accum_reg <= '0;
            gain_reg  <= GAIN_FULL;
            pend_reg  <= 1'b0;
            mute_reg  <= 1'b0;
        end
        else if (ctl.commit)
        begin
            count_reg <= count_next;
            accum_reg <= accum_next;
            gain_reg  <= gain_next;
            pend_reg  <= pend_next;
            mute_reg  <= mute_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            mod_reg <= mod_next;
        end
        else if (ctl.eng_step && ctl.eng_last)
        begin
            mod_reg <= reduced[COUNT_WIDTH-1:0];
        end
        if (ctl.eng_start)
        begin
            prod_reg <= rat.pos ? PROD_W'(t_now) * PROD_W'(rat.mag) : '0;
            rem_reg  <= '0;
        end
        else if (ctl.eng_step)
        begin
            prod_reg <= prod_reg << 1;
            rem_reg  <= reduced[COUNT_WIDTH-1:0];
        end
    end

endmodule

// ----- rtl/clock_synced_mute_bank.sv -----
// ============================================================================
// clock_synced_mute_bank
// Eight-channel mute bank synchronised to a measured or internal clock.
// ============================================================================
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  in      | input     | in_valid/in_stall | in_data (in_item_t), one tick
//  out     | output    | out_valid/out_stall| out_data (out_item_t), gains+masks
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
//  one transaction a cycle while each lane's stored phase remainder matches
//  the period in use; otherwise the transaction is held while the shared
//  bit-serial remainder sequencer runs. a period change between clock ticks,
//  a ratio write or a period below 32 ticks can force that path. reset needs
//  no clearing pass. the output register lets a new transaction enter in the
//  cycle the last result is taken; a stalled result holds the input off.
// ============================================================================
module clock_synced_mute_bank #(
    parameter int CHANNELS    = cmb_pkg::MAX_CHANNELS,
    parameter int COUNT_WIDTH = cmb_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  cmb_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output cmb_pkg::out_item_t               out_data,
    input  logic                             cfg_we,
    input  logic [cmb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cmb_pkg::*;

    localparam int DIV_STEPS = COUNT_WIDTH + MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // configuration
    logic [CFG_DATA_W-1:0]   ratios_reg;
    logic [MAX_CHANNELS-1:0] auto_reg;
    logic [MAX_CHANNELS-1:0] soft_reg;
    logic [PERIOD_W-1:0]     dperiod_reg;
    logic [IGNORE_W-1:0]     ignore_reg;
    logic [STEP_W-1:0]       ramp_reg;

    // flow control
    in_item_t                hold_reg;
    logic                    hold_valid_reg, hold_valid_next;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;
    logic                    eng_busy_reg;
    logic [CNT_W-1:0]        eng_cnt_reg;
    logic [COUNT_WIDTH-1:0]  eng_p_reg;
    logic                    mod_valid_reg, mod_valid_next;
    logic [COUNT_WIDTH-1:0]  pm_reg;

    in_item_t                src;
    logic                    out_free;
    logic                    accept;
    logic                    src_valid;
    logic                    mod_ready;
    logic                    commit;
    logic                    eng_start;
    logic                    eng_last;

    tb_flags_t               tb_flags;
    logic [COUNT_WIDTH-1:0]  p_ch;
    logic [COUNT_WIDTH-1:0]  t_now;

    lane_out_t               lane_res [MAX_CHANNELS];
    logic [GAIN_W-1:0]       gain_v   [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] muted_v;
    logic [MAX_CHANNELS-1:0] pend_v;
    logic [MAX_CHANNELS-1:0] ok_v;
    out_item_t               out_next;

    always_comb
    begin
        src       = hold_valid_reg ? hold_reg : in_data;
        out_free  = !out_valid_reg || !out_stall;
        in_stall  = hold_valid_reg || eng_busy_reg || !out_free;
        accept    = in_valid && !in_stall;
        src_valid = hold_valid_reg || accept;
        mod_ready = tb_flags.t_zero || (mod_valid_reg && (pm_reg == p_ch));
        commit    = src_valid && !eng_busy_reg && out_free && mod_ready;
        eng_start = accept && !mod_ready;
        eng_last  = eng_busy_reg && (eng_cnt_reg == CNT_W'(1));
    end

    cmb_timebase #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timebase (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (commit),
        .item           (src),
        .default_period (dperiod_reg),
        .ignore_ticks   (ignore_reg),
        .flags          (tb_flags),
        .p_ch           (p_ch),
        .t_now          (t_now)
    );

    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_lane
        if (i < CHANNELS)
        begin : g_on
            lane_ctl_t ctl;
            always_comb
            begin
                ctl.commit    = commit;
                ctl.tick      = tb_flags.tick;
                ctl.rst       = src.reset_edge;
                ctl.restart   = tb_flags.restart;
                ctl.t_zero    = tb_flags.t_zero;
                ctl.t_sat     = tb_flags.t_sat;
                ctl.press     = src.press_mask[i];
                ctl.auto_en   = auto_reg[i];
                ctl.soft_en   = soft_reg[i];
                ctl.eng_start = eng_start;
                ctl.eng_step  = eng_busy_reg;
                ctl.eng_last  = eng_last;
            end

            cmb_lane #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .ratio_raw (ratios_reg[RATIO_W*i +: RATIO_W]),
                .ramp_step (ramp_reg),
                .p_ch      (p_ch),
                .p_eng     (eng_p_reg),
                .t_now     (t_now),
                .result    (lane_res[i])
            );
        end
        else
        begin : g_off
            assign lane_res[i] = '{gain: '0, muted: 1'b0, pending: 1'b0, mod_ok: 1'b1};
        end
    end

    // merge the lanes into one result
    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            gain_v[i]  = lane_res[i].gain;
            muted_v[i] = lane_res[i].muted;
            pend_v[i]  = lane_res[i].pending;
            ok_v[i]    = lane_res[i].mod_ok;
        end
        out_next.gain_ch0     = gain_v[0];
        out_next.gain_ch1     = gain_v[1];
        out_next.gain_ch2     = gain_v[2];
        out_next.gain_ch3     = gain_v[3];
        out_next.gain_ch4     = gain_v[4];
        out_next.gain_ch5     = gain_v[5];
        out_next.gain_ch6     = gain_v[6];
        out_next.gain_ch7     = gain_v[7];
        out_next.muted_mask   = muted_v;
        out_next.pending_mask = pend_v;
        mod_valid_next        = &ok_v;
        hold_valid_next       = hold_valid_reg;
        if (eng_start)
        begin
            hold_valid_next = 1'b1;
        end
        else if (commit)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratios_reg  <= RATIOS_RST;
            auto_reg    <= AUTO_RST;
            soft_reg    <= SOFT_RST;
            dperiod_reg <= PERIOD_RST;
            ignore_reg  <= IGNORE_RST;
            ramp_reg    <= STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RATIOS: ratios_reg  <= cfg_data;
                REG_AUTO:   auto_reg    <= cfg_data[MAX_CHANNELS-1:0];
                REG_SOFT:   soft_reg    <= cfg_data[MAX_CHANNELS-1:0];
                REG_PERIOD: dperiod_reg <= cfg_data[PERIOD_W-1:0];
                REG_IGNORE: ignore_reg  <= cfg_data[IGNORE_W-1:0];
                REG_RAMP:   ramp_reg    <= cfg_data[STEP_W-1:0];
                default:    ;
            endcase
        end
    end

    // control: hold slot, remainder sequencer, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            eng_busy_reg   <= 1'b0;
            eng_cnt_reg    <= '0;
            mod_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (eng_start)
            begin
                eng_busy_reg <= 1'b1;
                eng_cnt_reg  <= CNT_W'(DIV_STEPS);
            end
            else if (eng_busy_reg)
            begin
                eng_cnt_reg <= eng_cnt_reg - 1'b1;
                if (eng_last)
                begin
                    eng_busy_reg <= 1'b0;
                end
            end
            // the stored phases follow the ratios they were built from
            if (cfg_we && (cfg_index == REG_RATIOS))
            begin
                mod_valid_reg <= 1'b0;
            end
            else if (eng_last)
            begin
                mod_valid_reg <= 1'b1;
            end
            else if (commit)
            begin
                mod_valid_reg <= mod_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= in_data;
        end
        if (eng_start)
        begin
            eng_p_reg <= p_ch;
        end
        if (eng_last)
        begin
            pm_reg <= eng_p_reg;
        end
        else if (commit)
        begin
            pm_reg <= p_ch;
        end
        if (commit)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/cmb_checker.sv -----
// ============================================================================
// cmb_checker
// Port-level checks on the mute bank, attached by bind.
// ============================================================================
module cmb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input cmb_pkg::out_item_t  out_data
);
    import cmb_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // a full, stalled output register must block new input
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output register full");

    // nothing is presented as reset is released
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid coming out of reset");

endmodule

bind clock_synced_mute_bank cmb_checker u_cmb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
